### rtl/core/assert_macros.svh
// Assertion macros shared by the sector write sequencer RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/apsw_pkg.sv
// Shared types and constants of the ATA PIO sector write sequencer.
// No dependencies; every module of the block imports this package.
package apsw_pkg;

	localparam int SECTOR_BYTES = 512;
	localparam int FILL_W = $clog2(SECTOR_BYTES + 1);
	localparam int LBA_W = 28;

	localparam logic [15:0] PORT_DATA  = 16'h01F0;
	localparam logic [15:0] PORT_COUNT = 16'h01F2;
	localparam logic [15:0] PORT_LBA0  = 16'h01F3;
	localparam logic [15:0] PORT_LBA1  = 16'h01F4;
	localparam logic [15:0] PORT_LBA2  = 16'h01F5;
	localparam logic [15:0] PORT_DRIVE = 16'h01F6;
	localparam logic [15:0] PORT_CMD   = 16'h01F7;

	localparam logic [15:0] CMD_WRITE  = 16'h0030;
	localparam logic [15:0] COUNT_ONE  = 16'h0001;
	localparam logic [7:0]  ST_READY   = 8'h40;
	localparam logic [7:0]  ST_BUSY    = 8'hFF;
	localparam logic [3:0]  DRIVE_MASK = 4'hF;
	localparam logic [1:0]  WIDTH_WORD = 2'd2;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		PC_DATA,
		PC_COUNT,
		PC_LBA0,
		PC_LBA1,
		PC_LBA2,
		PC_DRIVE,
		PC_CMD,
		PC_OTHER
	} port_code_t;

	// Classified access as it travels from the front end to the back end.
	typedef struct packed {
		logic        is_read;
		port_code_t  pcode;
		logic        is_word;
		logic        count_one;
		logic        cmd_write;
		logic [15:0] wdata;
	} item_t;

	typedef struct packed {
		logic [7:0]       status_byte;
		logic [1:0]       bytes_out;
		logic [8:0]       byte_offset;
		logic [7:0]       first_byte;
		logic [7:0]       second_byte;
		logic             sector_done;
		logic [LBA_W-1:0] sector_number;
	} result_t;

endpackage

### rtl/core/ata_pio_sector_write_fsm.sv
// ATA PIO single-sector LBA28 write sequencer. Each port access is one item and yields
// one result item after it has passed the queue and the result register; one item per
// cycle is sustained while out_ready is high. The front end decodes the access, a
// two-entry queue decouples it from the back end, and a result register holds the
// status byte, any delivered sector bytes and the sector commit flag until taken.
// Configuration: register 0 (byte address 0) is disk_ready. Depends on apsw_pkg.
module ata_pio_sector_write_fsm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [15:0]                  port,
	input  logic [15:0]                  wdata,
	input  logic [1:0]                   access_bytes,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   status_byte,
	output logic [1:0]                   bytes_out,
	output logic [8:0]                   byte_offset,
	output logic [7:0]                   first_byte,
	output logic [7:0]                   second_byte,
	output logic                         sector_done,
	output logic [apsw_pkg::LBA_W-1:0]   sector_number
);
	import apsw_pkg::*;

	localparam logic REG_DISK_READY = 1'b0;

	logic    disk_ready_q;
	logic    reg_idx;
	item_t   front_item;
	item_t   q_item;
	logic    q_valid;
	logic    q_pop;
	result_t res;

	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_DISK_READY) ? {31'b0, disk_ready_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_ready_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_DISK_READY) begin
			disk_ready_q <= pwdata[0];
		end
	end

	apsw_front u_front (
		.kind         (kind),
		.port         (port),
		.wdata        (wdata),
		.access_bytes (access_bytes),
		.item         (front_item)
	);

	apsw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_item  (front_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_item   (q_item)
	);

	apsw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.disk_ready (disk_ready_q),
		.item_valid (q_valid),
		.item_ready (q_pop),
		.item       (q_item),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res)
	);

	assign status_byte   = res.status_byte;
	assign bytes_out     = res.bytes_out;
	assign byte_offset   = res.byte_offset;
	assign first_byte    = res.first_byte;
	assign second_byte   = res.second_byte;
	assign sector_done   = res.sector_done;
	assign sector_number = res.sector_number;

endmodule

### rtl/core/apsw_front.sv
// Front end of the sector write sequencer: decodes the port address and data of an item.
// Depends on apsw_pkg.
module apsw_front (
	input  logic           kind,
	input  logic [15:0]    port,
	input  logic [15:0]    wdata,
	input  logic [1:0]     access_bytes,
	output apsw_pkg::item_t item
);
	import apsw_pkg::*;

	port_code_t pcode;

	always_comb begin
		unique case (port)
			PORT_DATA:  pcode = PC_DATA;
			PORT_COUNT: pcode = PC_COUNT;
			PORT_LBA0:  pcode = PC_LBA0;
			PORT_LBA1:  pcode = PC_LBA1;
			PORT_LBA2:  pcode = PC_LBA2;
			PORT_DRIVE: pcode = PC_DRIVE;
			PORT_CMD:   pcode = PC_CMD;
			default:    pcode = PC_OTHER;
		endcase
	end

	// Any width other than a word is handled as a byte write.
	always_comb begin
		item.is_read   = kind;
		item.pcode     = pcode;
		item.is_word   = (access_bytes == WIDTH_WORD);
		item.count_one = (wdata == COUNT_ONE);
		item.cmd_write = (wdata == CMD_WRITE);
		item.wdata     = wdata;
	end

endmodule

### rtl/core/apsw_queue.sv
// Short queue between the front and back ends of the sector write sequencer.
// Depends on apsw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module apsw_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  apsw_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output apsw_pkg::item_t pop_item
);
	import apsw_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push_fire;
	logic              pop_fire;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop_fire) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	`ASSERT_ALWAYS(a_q_cnt_bound, cnt_q <= QCNT_W'(QDEPTH), "queue count beyond depth")
	`ASSERT_NEXT(a_q_push_only, push_fire && !pop_fire, cnt_q == $past(cnt_q) + QCNT_W'(1), "queue count missed a push")

endmodule

### rtl/core/apsw_back.sv
// Back end of the sector write sequencer: step state, LBA and fill tracking, result register.
// Depends on apsw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module apsw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              disk_ready,
	input  logic              item_valid,
	output logic              item_ready,
	input  apsw_pkg::item_t   item,
	output logic              res_valid,
	input  logic              res_ready,
	output apsw_pkg::result_t res
);
	import apsw_pkg::*;

	typedef enum logic [8:0] {
		STEP_IDLE   = 9'b000000001,
		STEP_COUNT  = 9'b000000010,
		STEP_LBA0   = 9'b000000100,
		STEP_LBA1   = 9'b000001000,
		STEP_LBA2   = 9'b000010000,
		STEP_DRIVE  = 9'b000100000,
		STEP_CMD    = 9'b001000000,
		STEP_STATUS = 9'b010000000,
		STEP_DATA   = 9'b100000000
	} step_t;

	step_t             step_q, step_d;
	logic [LBA_W-1:0]  lba_q, lba_d;
	logic [FILL_W-1:0] fill_q, fill_d, fill_p1;
	logic              out_valid_q;
	result_t           res_q, res_d;
	logic              pop;
	logic              room1, room2;
	logic [1:0]        nbytes;
	logic [31:0]       fill_ext;

	assign pop        = item_valid && (!out_valid_q || res_ready);
	assign item_ready = pop;
	assign res_valid  = out_valid_q;
	assign res        = res_q;

	assign fill_p1  = fill_q + FILL_W'(1);
	assign room1    = fill_q < FILL_W'(SECTOR_BYTES);
	assign room2    = fill_p1 < FILL_W'(SECTOR_BYTES);
	assign fill_ext = 32'(fill_q);

	always_comb begin
		step_d = STEP_IDLE;
		lba_d  = lba_q;
		fill_d = fill_q;
		nbytes = 2'd0;
		res_d  = '0;
		if (item.is_read) begin
			if (item.pcode == PC_CMD && disk_ready) begin
				if (step_q == STEP_IDLE) begin
					step_d = STEP_COUNT;
				end else if (step_q == STEP_STATUS) begin
					step_d = STEP_DATA;
				end
			end
		end else begin
			unique case (step_q)
				STEP_COUNT: begin
					lba_d  = '0;
					fill_d = '0;
					if (item.pcode == PC_COUNT && item.count_one) begin
						step_d = STEP_LBA0;
					end
				end
				// LBA bytes are merged even when the port is wrong; the
				// next sequence clears them at the sector count write.
				STEP_LBA0: begin
					lba_d = lba_q | LBA_W'(item.wdata[7:0]);
					if (item.pcode == PC_LBA0) begin
						step_d = STEP_LBA1;
					end
				end
				STEP_LBA1: begin
					lba_d = lba_q | (LBA_W'(item.wdata[7:0]) << 8);
					if (item.pcode == PC_LBA1) begin
						step_d = STEP_LBA2;
					end
				end
				STEP_LBA2: begin
					lba_d = lba_q | (LBA_W'(item.wdata[7:0]) << 16);
					if (item.pcode == PC_LBA2) begin
						step_d = STEP_DRIVE;
					end
				end
				STEP_DRIVE: begin
					lba_d = lba_q | (LBA_W'(item.wdata[3:0] & DRIVE_MASK) << 24);
					if (item.pcode == PC_DRIVE) begin
						step_d = STEP_CMD;
					end
				end
				STEP_CMD: begin
					if (item.pcode == PC_CMD && item.cmd_write) begin
						step_d = STEP_STATUS;
					end
				end
				STEP_DATA: begin
					if (item.pcode == PC_DATA) begin
						// Bytes that would land past the end of the sector are dropped.
						if (room1) begin
							nbytes            = 2'd1;
							res_d.byte_offset = fill_ext[8:0];
							res_d.first_byte  = item.is_word ? item.wdata[7:0]
								: item.wdata[15:8];
							if (item.is_word && room2) begin
								nbytes             = 2'd2;
								res_d.second_byte  = item.wdata[15:8];
							end
						end
						fill_d = fill_q + FILL_W'(nbytes);
						if (fill_d == FILL_W'(SECTOR_BYTES)) begin
							step_d              = STEP_IDLE;
							res_d.sector_done   = 1'b1;
							res_d.sector_number = lba_q;
						end else begin
							step_d = STEP_DATA;
						end
					end
				end
				default: begin
					step_d = STEP_IDLE;
				end
			endcase
		end
		res_d.bytes_out   = nbytes;
		res_d.status_byte = (step_d == STEP_COUNT || step_d == STEP_DATA) ? ST_READY
			: ST_BUSY;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			lba_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q <= step_d;
				lba_q  <= lba_d;
				fill_q <= fill_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_W'(SECTOR_BYTES), "fill count past sector size")
	`ASSERT_ALWAYS(a_done_idle, !(out_valid_q && res_q.sector_done) || step_q == STEP_IDLE, "sector done without return to idle")

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the ATA PIO sector write sequencer: it drives port accesses
// through valid/ready, predicts each status and data result and compares them in order.
// Depends on apsw_pkg and ata_pio_sector_write_fsm.
module testbench;
	import apsw_pkg::*;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;
	localparam int REG_DISK_READY = 0;
	localparam int TAIL_NONE = 0;
	localparam int TAIL_HEADER = 1;
	localparam int TAIL_OPEN_STATUS = 2;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS = 50;
	localparam int SETTLE_CYCLES = 8;

	typedef enum logic [3:0] {
		STEP_WAIT_STATUS,
		STEP_COUNT,
		STEP_LBA0,
		STEP_LBA1,
		STEP_LBA2,
		STEP_DRIVE,
		STEP_CMD,
		STEP_WAIT_DRQ,
		STEP_DATA
	} seq_step_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] port;
		logic [15:0] wdata;
		logic [1:0]  access_bytes;
	} access_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [15:0] port = '0;
	logic [15:0] wdata = '0;
	logic [1:0] access_bytes = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] status_byte;
	logic [1:0] bytes_out;
	logic [8:0] byte_offset;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic sector_done;
	logic [LBA_W-1:0] sector_number;

	ata_pio_sector_write_fsm dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .port(port), .wdata(wdata), .access_bytes(access_bytes),
		.out_valid(out_valid), .out_ready(out_ready),
		.status_byte(status_byte), .bytes_out(bytes_out), .byte_offset(byte_offset),
		.first_byte(first_byte), .second_byte(second_byte),
		.sector_done(sector_done), .sector_number(sector_number)
	);

	access_t pending_accesses[$];
	result_t expected_responses[$];
	int mismatch_count = 0;

	// Predictor state, mirrors the block's sequencer.
	seq_step_t seq_step = STEP_WAIT_STATUS;
	logic [LBA_W-1:0] lba_acc = '0;
	int fill_bytes = 0;
	logic cfg_disk_ready = 1'b0;

	// Generator's view of where the sequence stands.
	bit gen_in_data = 1'b0;
	int gen_fill = 0;
	int gen_items = 0;

	// Sender and receiver pacing.
	bit item_taken = 1'b0;
	bit drain_wait = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int burst_count = 0;
	logic [15:0] ready_pattern = '1;
	int pattern_age = 0;
	int quiet_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic sequencer_response(input access_t a, output result_t r);
		logic advance;
		logic hold;
		logic [7:0] want [2];
		int nwant;
		int i;
		r = '0;
		advance = 1'b0;
		hold = 1'b0;
		if (a.kind == KIND_READ) begin
			if (seq_step == STEP_WAIT_STATUS || seq_step == STEP_WAIT_DRQ)
				advance = (a.port == PORT_CMD) && cfg_disk_ready;
		end else begin
			case (seq_step)
			STEP_COUNT: begin
				lba_acc = '0;
				fill_bytes = 0;
				advance = (a.port == PORT_COUNT) && (a.wdata == COUNT_ONE);
			end
			STEP_LBA0: begin
				advance = (a.port == PORT_LBA0);
				lba_acc[7:0] = lba_acc[7:0] | a.wdata[7:0];
			end
			STEP_LBA1: begin
				advance = (a.port == PORT_LBA1);
				lba_acc[15:8] = lba_acc[15:8] | a.wdata[7:0];
			end
			STEP_LBA2: begin
				advance = (a.port == PORT_LBA2);
				lba_acc[23:16] = lba_acc[23:16] | a.wdata[7:0];
			end
			STEP_DRIVE: begin
				advance = (a.port == PORT_DRIVE);
				lba_acc[27:24] = lba_acc[27:24] | (a.wdata[3:0] & DRIVE_MASK);
			end
			STEP_CMD: begin
				advance = (a.port == PORT_CMD) && (a.wdata == CMD_WRITE);
			end
			STEP_DATA: begin
				if (a.port == PORT_DATA) begin
					if (a.access_bytes == WIDTH_WORD) begin
						want[0] = a.wdata[7:0];
						want[1] = a.wdata[15:8];
						nwant = 2;
					end else begin
						want[0] = a.wdata[15:8];
						want[1] = '0;
						nwant = 1;
					end
					r.byte_offset = 9'(fill_bytes);
					// Bytes past the end of the sector are dropped.
					for (i = 0; i < nwant; i++) begin
						if (fill_bytes < SECTOR_BYTES) begin
							if (r.bytes_out == 2'd0)
								r.first_byte = want[i];
							else
								r.second_byte = want[i];
							r.bytes_out = r.bytes_out + 2'd1;
							fill_bytes++;
						end
					end
					if (r.bytes_out == 2'd0)
						r.byte_offset = '0;
					hold = 1'b1;
					if (fill_bytes == SECTOR_BYTES) begin
						advance = 1'b1;
						r.sector_done = 1'b1;
						r.sector_number = lba_acc;
					end
				end
			end
			default: ;
			endcase
		end
		if (advance)
			seq_step = (seq_step == STEP_DATA) ? STEP_WAIT_STATUS : seq_step_t'(seq_step + 1);
		else if (!hold)
			seq_step = STEP_WAIT_STATUS;
		r.status_byte = (seq_step == STEP_COUNT || seq_step == STEP_DATA) ? ST_READY : ST_BUSY;
	endtask

	task automatic compare_response(input result_t got, input result_t want);
		if (got.status_byte !== want.status_byte)
			report_mismatch($sformatf("status_byte got %h expected %h",
				got.status_byte, want.status_byte));
		if (got.bytes_out !== want.bytes_out)
			report_mismatch($sformatf("bytes_out got %0d expected %0d",
				got.bytes_out, want.bytes_out));
		if (got.byte_offset !== want.byte_offset)
			report_mismatch($sformatf("byte_offset got %0d expected %0d",
				got.byte_offset, want.byte_offset));
		if (got.first_byte !== want.first_byte)
			report_mismatch($sformatf("first_byte got %h expected %h",
				got.first_byte, want.first_byte));
		if (got.second_byte !== want.second_byte)
			report_mismatch($sformatf("second_byte got %h expected %h",
				got.second_byte, want.second_byte));
		if (got.sector_done !== want.sector_done)
			report_mismatch($sformatf("sector_done got %b expected %b",
				got.sector_done, want.sector_done));
		if (got.sector_number !== want.sector_number)
			report_mismatch($sformatf("sector_number got %h expected %h",
				got.sector_number, want.sector_number));
	endtask

	task automatic queue_access(input logic k, input logic [15:0] p, input logic [15:0] d,
			input logic [1:0] w);
		access_t a;
		a.kind = k;
		a.port = p;
		a.wdata = d;
		a.access_bytes = w;
		pending_accesses.push_back(a);
		gen_items++;
	endtask

	// A random access that is never the one the sequence expects next, so the
	// sequencer is known to be back at its first step afterwards.
	task automatic queue_stray(input logic want_kind, input logic [15:0] want_port);
		logic k;
		logic [15:0] p;
		k = 1'($urandom_range(0, 1));
		p = ($urandom_range(0, 1) == 0) ? PORT_DATA + 16'($urandom_range(0, 7))
			: 16'($urandom);
		if (k == want_kind && p == want_port)
			k = ~k;
		queue_access(k, p, 16'($urandom), 2'($urandom_range(0, 3)));
	endtask

	task automatic queue_header(input bit ready, input bit may_break, input bit stop_at_cmd);
		seq_step_t s;
		logic k;
		logic [15:0] p;
		logic [15:0] d;
		int i;
		int n;
		gen_in_data = 1'b0;
		n = stop_at_cmd ? 7 : 8;
		for (i = 0; i < n; i++) begin
			s = seq_step_t'(i);
			k = (s == STEP_WAIT_STATUS || s == STEP_WAIT_DRQ) ? KIND_READ : KIND_WRITE;
			d = 16'($urandom);
			case (s)
			STEP_COUNT: begin
				p = PORT_COUNT;
				d = COUNT_ONE;
			end
			STEP_LBA0: p = PORT_LBA0;
			STEP_LBA1: p = PORT_LBA1;
			STEP_LBA2: p = PORT_LBA2;
			STEP_DRIVE: p = PORT_DRIVE;
			STEP_CMD: begin
				p = PORT_CMD;
				d = CMD_WRITE;
			end
			default: p = PORT_CMD;
			endcase
			if (may_break && $urandom_range(0, 15) == 0) begin
				queue_stray(k, p);
				return;
			end
			queue_access(k, p, d, 2'($urandom_range(0, 3)));
		end
		gen_in_data = ready && !stop_at_cmd;
		gen_fill = 0;
	endtask

	task automatic queue_data_run(input int len);
		int i;
		bit word;
		logic [1:0] w;
		for (i = 0; i < len && gen_in_data; i++) begin
			if ($urandom_range(0, 99) == 0) begin
				queue_stray(KIND_WRITE, PORT_DATA);
				gen_in_data = 1'b0;
			end else begin
				word = ($urandom_range(0, 9) < 7);
				// A word with one byte of room left makes the sector overfill.
				if (gen_fill == SECTOR_BYTES - 1)
					word = ($urandom_range(0, 3) != 0);
				if (word) begin
					w = WIDTH_WORD;
				end else begin
					w = 2'($urandom_range(0, 2));
					if (w == WIDTH_WORD)
						w = 2'd3;
				end
				queue_access(KIND_WRITE, PORT_DATA, 16'($urandom), w);
				gen_fill += word ? 2 : 1;
				if (gen_fill >= SECTOR_BYTES)
					gen_in_data = 1'b0;
			end
		end
	endtask

	task automatic queue_random_phase(input int target, input bit ready, input int tail);
		int start;
		start = gen_items;
		while (gen_items - start < target) begin
			if (gen_in_data)
				queue_data_run($urandom_range(8, 64));
			else if ($urandom_range(0, 99) < (ready ? 85 : 50))
				queue_header(ready, 1'b1, 1'b0);
			else
				repeat ($urandom_range(1, 3)) queue_stray(KIND_READ, PORT_CMD);
		end
		if (tail == TAIL_HEADER && !gen_in_data) begin
			queue_header(ready, 1'b0, 1'b0);
		end else if (tail == TAIL_OPEN_STATUS) begin
			while (gen_in_data)
				queue_data_run(64);
			queue_header(ready, 1'b0, 1'b1);
		end
	endtask

	task automatic write_config(input int index, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(4 * index);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (index == REG_DISK_READY)
			cfg_disk_ready = value[0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_until_idle();
		while (pending_accesses.size() != 0 || in_valid || expected_responses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sender: bursts of items separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || item_taken) begin
			access_t a;
			item_taken = 1'b0;
			if (burst_left == 0) begin
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				burst_left = $urandom_range(1, 40);
				drain_wait = (burst_count % 8 == 3);
				burst_count++;
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (drain_wait && expected_responses.size() != 0) begin
				in_valid <= 1'b0;
			end else if (pending_accesses.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				drain_wait = 1'b0;
				a = pending_accesses.pop_front();
				in_valid <= 1'b1;
				kind <= a.kind;
				port <= a.port;
				wdata <= a.wdata;
				access_bytes <= a.access_bytes;
				burst_left--;
			end
		end
	end

	// Receiver: a rotating ready pattern, replaced every so often.
	always @(negedge clk) begin
		if (arst_n) begin
			if (pattern_age == 0) begin
				pattern_age = 96;
				if ($urandom_range(0, 3) == 0)
					ready_pattern = '1;
				else
					ready_pattern = 16'($urandom) | 16'h0001;
			end
			pattern_age--;
			out_ready <= ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
		end
	end

	always @(posedge clk) begin : scoreboard
		access_t taken;
		result_t predicted;
		result_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				taken.kind = kind;
				taken.port = port;
				taken.wdata = wdata;
				taken.access_bytes = access_bytes;
				sequencer_response(taken, predicted);
				expected_responses.push_back(predicted);
				item_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				got = {status_byte, bytes_out, byte_offset, first_byte, second_byte,
					sector_done, sector_number};
				if (expected_responses.size() == 0)
					report_mismatch("result item with no access outstanding");
				else
					compare_response(got, expected_responses.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", quiet_cycles);
				$display("FAIL ata_pio_sector_write_fsm");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Store not ready: status reads must not start the sequence.
		write_config(REG_DISK_READY, 32'd0);
		queue_access(KIND_READ, PORT_CMD, 16'h0000, 2'd2);
		queue_access(KIND_WRITE, 16'hFFFF, 16'hFFFF, 2'd3);
		queue_access(KIND_READ, 16'h0000, 16'h0000, 2'd0);
		wait_until_idle();

		write_config(REG_DISK_READY, 32'd1);
		queue_access(KIND_WRITE, PORT_COUNT, COUNT_ONE, 2'd2);
		queue_access(KIND_READ, 16'hFFFF, 16'hFFFF, 2'd1);
		// Sector count compared over all 16 bits.
		queue_access(KIND_READ, PORT_CMD, 16'h0000, 2'd2);
		queue_access(KIND_WRITE, PORT_COUNT, 16'h0101, 2'd2);
		// Wrong port while the count is expected.
		queue_access(KIND_READ, PORT_CMD, 16'h0000, 2'd2);
		queue_access(KIND_WRITE, PORT_LBA0, COUNT_ONE, 2'd1);
		// Full-width LBA values, then the command compared over all 16 bits.
		queue_access(KIND_READ, PORT_CMD, 16'h0000, 2'd2);
		queue_access(KIND_WRITE, PORT_COUNT, COUNT_ONE, 2'd0);
		queue_access(KIND_WRITE, PORT_LBA0, 16'hFFA5, 2'd2);
		queue_access(KIND_WRITE, PORT_LBA1, 16'h005A, 2'd1);
		queue_access(KIND_WRITE, PORT_LBA2, 16'h80FF, 2'd3);
		queue_access(KIND_WRITE, PORT_DRIVE, 16'hFFFF, 2'd2);
		queue_access(KIND_WRITE, PORT_CMD, 16'h1030, 2'd2);
		// All-zero header, then a write where the second status read belongs.
		queue_access(KIND_READ, PORT_CMD, 16'hFFFF, 2'd3);
		queue_access(KIND_WRITE, PORT_COUNT, COUNT_ONE, 2'd2);
		queue_access(KIND_WRITE, PORT_LBA0, 16'h0000, 2'd2);
		queue_access(KIND_WRITE, PORT_LBA1, 16'h0000, 2'd2);
		queue_access(KIND_WRITE, PORT_LBA2, 16'h0000, 2'd2);
		queue_access(KIND_WRITE, PORT_DRIVE, 16'h0000, 2'd0);
		queue_access(KIND_WRITE, PORT_CMD, CMD_WRITE, 2'd2);
		queue_access(KIND_WRITE, PORT_CMD, CMD_WRITE, 2'd2);
		wait_until_idle();

		queue_random_phase(275, 1'b1, TAIL_NONE);
		wait_until_idle();
		queue_random_phase(275, 1'b1, TAIL_HEADER);
		wait_until_idle();
		// A sector already under way must still complete with the store not ready.
		write_config(REG_DISK_READY, 32'd0);
		queue_random_phase(275, 1'b0, TAIL_NONE);
		wait_until_idle();
		write_config(REG_DISK_READY, 32'd1);
		queue_random_phase(275, 1'b1, TAIL_OPEN_STATUS);
		wait_until_idle();
		// The second status read fails once the store has gone away.
		write_config(REG_DISK_READY, 32'd0);
		queue_access(KIND_READ, PORT_CMD, 16'($urandom), 2'd2);
		queue_random_phase(275, 1'b0, TAIL_NONE);
		wait_until_idle();
		write_config(REG_DISK_READY, 32'd1);
		queue_random_phase(275, 1'b1, TAIL_NONE);
		wait_until_idle();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_responses.size() == 0)
			$display("PASS ata_pio_sector_write_fsm");
		else
			$display("FAIL ata_pio_sector_write_fsm");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/apsw_pkg.sv
rtl/core/apsw_front.sv
rtl/core/apsw_queue.sv
rtl/core/apsw_back.sv
rtl/core/ata_pio_sector_write_fsm.sv
bench/testbench.sv
